@@ design/rotation_matrix_to_euler_angles_core_defines.svh @@
// Assertion macros for the core design file.
`ifndef ROTATION_MATRIX_TO_EULER_ANGLES_CORE_DEFINES_SVH
`define ROTATION_MATRIX_TO_EULER_ANGLES_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define RMEA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define RMEA_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define RMEA_ASSERT(label, prop, msg)
`define RMEA_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

@@ design/rmea_pkg.sv @@
package rmea_pkg;

  localparam int CordicStagesDef = 16;
  localparam int FractionBitsDef = 14;
  localparam int PiQ13           = 25736;
  localparam int HalfPiQ13       = 12868;
  localparam longint PiQ30       = 64'd3373259426;

  typedef enum logic [1:0] {
    CASE_NORMAL = 2'd0,
    CASE_NEG    = 2'd1,
    CASE_POS    = 2'd2
  } pose_case_e;

  function automatic longint atan_q30(input int i);
    longint v;
    case (i)
      0:       v = 64'h3243F6A8;
      1:       v = 64'h1DAC6705;
      2:       v = 64'h0FADBAFC;
      3:       v = 64'h07F56EA6;
      4:       v = 64'h03FEAB76;
      5:       v = 64'h01FFD55B;
      6:       v = 64'h00FFFAAA;
      7:       v = 64'h007FFF55;
      8:       v = 64'h003FFFEA;
      9:       v = 64'h001FFFFD;
      10:      v = 64'h000FFFFF;
      11:      v = 64'h0007FFFF;
      12:      v = 64'h0003FFFF;
      13:      v = 64'h0001FFFF;
      14:      v = 64'h0000FFFF;
      15:      v = 64'h00007FFF;
      16:      v = 64'h00003FFF;
      17:      v = 64'h00001FFF;
      18:      v = 64'h00000FFF;
      19:      v = 64'h000007FF;
      20:      v = 64'h000003FF;
      21:      v = 64'h000001FF;
      22:      v = 64'h000000FF;
      default: v = 64'h0000007F;
    endcase
    return v;
  endfunction

  function automatic longint from_q30(input longint v, input int fb);
    int s;
    s = 30 - fb;
    if (s == 0) return v;
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint atan_fb(input int i, input int fb);
    return from_q30(atan_q30(i), fb);
  endfunction

  function automatic longint pi_fb(input int fb);
    return from_q30(PiQ30, fb);
  endfunction

endpackage

@@ design/rotation_matrix_to_euler_angles_core.sv @@
// Channel  Dir  Bits  Contents
// s_axis   in   112   r20, r21, r22, r10, r00, r01, r02 (Q1.14)
// m_axis   out  136   pose case and both ZYX solutions, locked pitch and roll (Q3.13)
//
// One beat per cycle while the output is not stalled; the depth is set by the
// square-root pipeline (one result bit per stage) and the unrolled CORDIC.
// Reset clears only the valid bits; payload registers come up undefined.
// A stalled output holds the whole pipeline; nothing is dropped or repeated.
module rotation_matrix_to_euler_angles_core #(
  parameter int CORDIC_STAGES = rmea_pkg::CordicStagesDef,
  parameter int FRACTION_BITS = rmea_pkg::FractionBitsDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // r20, r21, r22, r10, r00, r01, r02, 16 bits each
  input  logic [111:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // pose_case 2, tilt_a 17, tilt_b 17, roll_a 16, roll_b 16, heading_a 16,
  // heading_b 16, tilt_locked 15, roll_locked 16, zero fill 5
  output logic [135:0] m_axis_tdata
);
  import rmea_pkg::*;

  localparam int FB   = FRACTION_BITS;
  localparam int EW   = FB + 3;
  localparam int DW   = FB + 6;
  localparam int ZW   = FB + 4;
  localparam int TW   = EW + 16;
  localparam int RMW  = 2 * FB + 1;
  localparam int CRW  = FB + 1;
  localparam int SQN  = FB + 1;
  localparam int CDN  = CORDIC_STAGES + 1;
  localparam int LAT  = 3 + SQN + CDN;
  localparam int BW   = 9 * DW + 2;
  localparam int RW   = ZW + 4;
  localparam int UpSh = (FB >= 14) ? (FB - 14) : 0;
  localparam int DnSh = (FB < 14) ? (14 - FB) : 1;
  localparam int RnSh = (FB > 13) ? (FB - 13) : 1;
  localparam int LfSh = (FB < 13) ? (13 - FB) : 0;
  localparam logic signed [EW-1:0] One = EW'(1) <<< FB;

  logic ce;
  logic vld_q [LAT];

  assign ce            = !vld_q[LAT-1] || m_axis_tready;
  assign s_axis_tready = ce;
  assign m_axis_tvalid = vld_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < LAT; k++) vld_q[k] <= 1'b0;
    end else if (ce) begin
      vld_q[0] <= s_axis_tvalid;
      for (int k = 1; k < LAT; k++) vld_q[k] <= vld_q[k-1];
    end
  end

  // scale entries
  logic signed [EW-1:0] sc_d [7];
  logic signed [EW-1:0] sc_q [7];
  pose_case_e           pc_d, pc1_q;

  for (genvar e = 0; e < 7; e++) begin : g_scale
    logic signed [15:0]   v;
    logic signed [TW-1:0] t;
    assign v = s_axis_tdata[16*e +: 16];
    always_comb begin
      t = TW'(v);
      if (FB >= 14) t = t <<< UpSh;
      else          t = (t + (TW'(1) <<< (DnSh - 1))) >>> DnSh;
      sc_d[e] = EW'(t);
    end
  end

  always_comb begin
    if (s_axis_tdata[15:0] == 16'hC000)      pc_d = CASE_NEG;
    else if (s_axis_tdata[15:0] == 16'h4000) pc_d = CASE_POS;
    else                                     pc_d = CASE_NORMAL;
  end

  always_ff @(posedge clk_i) begin
    if (ce) begin
      sc_q  <= sc_d;
      pc1_q <= pc_d;
    end
  end

  // clamp, square, select atan2 operands
  logic signed [EW-1:0]  rc;
  logic [CRW-1:0]        absr;
  logic [2*CRW-1:0]      sq;
  logic [RMW-1:0]        rem_d, rem_q;
  logic signed [DW-1:0]  e20, e21, e22, e10, e00, e01, e02;
  logic signed [DW-1:0]  yr, xr;
  logic [BW-1:0]         bun_d;
  logic [BW-1:0]         bun_q [SQN+1];

  assign e20 = DW'(rc);
  assign e21 = DW'(sc_q[1]);
  assign e22 = DW'(sc_q[2]);
  assign e10 = DW'(sc_q[3]);
  assign e00 = DW'(sc_q[4]);
  assign e01 = DW'(sc_q[5]);
  assign e02 = DW'(sc_q[6]);

  always_comb begin
    if (sc_q[0] > One)       rc = One;
    else if (sc_q[0] < -One) rc = -One;
    else                     rc = sc_q[0];
    absr  = (rc < 0) ? CRW'(-rc) : CRW'(rc);
    sq    = absr * absr;
    rem_d = (RMW'(1) << (2 * FB)) - RMW'(sq);
    case (pc1_q)
      CASE_NEG: begin
        yr = e01;
        xr = e02;
      end
      CASE_POS: begin
        yr = -e01;
        xr = -e02;
      end
      default: begin
        yr = e21;
        xr = e22;
      end
    endcase
    bun_d = {-e20, yr, xr, -e21, -e22, e10, e00, -e10, -e00, pc1_q};
  end

  always_ff @(posedge clk_i) begin
    if (ce) begin
      rem_q    <= rem_d;
      bun_q[0] <= bun_d;
      for (int k = 1; k < SQN + 1; k++) bun_q[k] <= bun_q[k-1];
    end
  end

  logic [CRW-1:0] root;

  rmea_isqrt #(.FB(FB)) u_isqrt (
    .clk_i  (clk_i),
    .ce_i   (ce),
    .rad_i  (rem_q),
    .root_o (root)
  );

  // CORDIC bank
  logic [BW-1:0]        bun;
  logic signed [DW-1:0] cy [5];
  logic signed [DW-1:0] cx [5];
  logic signed [ZW-1:0] cz [5];
  logic [1:0]           pcd_q [CDN];

  assign bun   = bun_q[SQN];
  assign cy[0] = bun[2+8*DW +: DW];
  assign cx[0] = DW'(root);
  assign cy[1] = bun[2+7*DW +: DW];
  assign cx[1] = bun[2+6*DW +: DW];
  assign cy[2] = bun[2+5*DW +: DW];
  assign cx[2] = bun[2+4*DW +: DW];
  assign cy[3] = bun[2+3*DW +: DW];
  assign cx[3] = bun[2+2*DW +: DW];
  assign cy[4] = bun[2+DW +: DW];
  assign cx[4] = bun[2 +: DW];

  for (genvar u = 0; u < 5; u++) begin : g_cordic
    rmea_cordic #(
      .DW     (DW),
      .ZW     (ZW),
      .STAGES (CORDIC_STAGES),
      .FB     (FB)
    ) u_cordic (
      .clk_i (clk_i),
      .ce_i  (ce),
      .y_i   (cy[u]),
      .x_i   (cx[u]),
      .z_o   (cz[u])
    );
  end

  always_ff @(posedge clk_i) begin
    if (ce) begin
      pcd_q[0] <= bun[1:0];
      for (int k = 1; k < CDN; k++) pcd_q[k] <= pcd_q[k-1];
    end
  end

  // round to Q3.13 and pack
  function automatic logic signed [17:0] to_q13(input logic signed [ZW-1:0] z,
                                                 input logic signed [17:0] lim);
    logic signed [RW-1:0] t;
    t = RW'(z);
    if (FB > 13) t = (t + (RW'(1) <<< (RnSh - 1))) >>> RnSh;
    else         t = t <<< LfSh;
    if (t > RW'(lim))  t = RW'(lim);
    if (t < -RW'(lim)) t = -RW'(lim);
    return 18'(t);
  endfunction

  pose_case_e           pco;
  logic signed [16:0]   ta_d, tb_d;
  logic signed [15:0]   ra_d, rb_d, ha_d, hb_d, rl_d;
  logic signed [14:0]   tl_d;
  logic [135:0]         out_d, out_q;
  logic signed [17:0]   ta_w, r1_w;

  assign pco = pose_case_e'(pcd_q[CDN-1]);

  always_comb begin
    ta_w = to_q13(cz[0], 18'(HalfPiQ13));
    r1_w = to_q13(cz[1], 18'(PiQ13));
    ta_d = '0;
    tb_d = '0;
    ra_d = '0;
    rb_d = '0;
    ha_d = '0;
    hb_d = '0;
    tl_d = '0;
    rl_d = '0;
    case (pco)
      CASE_NEG: begin
        tl_d = 15'(HalfPiQ13);
        rl_d = 16'(r1_w);
      end
      CASE_POS: begin
        tl_d = -15'(HalfPiQ13);
        rl_d = 16'(r1_w);
      end
      default: begin
        ta_d = 17'(ta_w);
        tb_d = 17'(PiQ13) - 17'(ta_w);
        ra_d = 16'(r1_w);
        rb_d = 16'(to_q13(cz[2], 18'(PiQ13)));
        ha_d = 16'(to_q13(cz[3], 18'(PiQ13)));
        hb_d = 16'(to_q13(cz[4], 18'(PiQ13)));
      end
    endcase
    out_d = {5'd0, rl_d, tl_d, hb_d, ha_d, rb_d, ra_d, tb_d, ta_d, pco};
  end

  always_ff @(posedge clk_i) begin
    if (ce) out_q <= out_d;
  end

  assign m_axis_tdata = out_q;

  `include "rotation_matrix_to_euler_angles_core_defines.svh"

  `RMEA_ASSERT(a_gimbal_zero, m_axis_tvalid && (out_q[1:0] != CASE_NORMAL) |-> (out_q[99:2] == '0), "gimbal beat carries normal angles")
  `RMEA_ASSERT(a_normal_lock_zero, m_axis_tvalid && (out_q[1:0] == CASE_NORMAL) |-> (out_q[130:100] == '0), "normal beat carries locked angles")
  `RMEA_ASSERT(a_tilt_pair, m_axis_tvalid && (out_q[1:0] == CASE_NORMAL) |-> (17'(out_q[18:2] + out_q[35:19]) == 17'(PiQ13)), "tilt solutions do not sum to pi")
  `RMEA_ASSERT(a_lock_sign, m_axis_tvalid && (out_q[1:0] == CASE_POS) |-> out_q[114], "locked pitch sign wrong")

endmodule

@@ design/rmea_isqrt.sv @@
module rmea_isqrt #(
  parameter int FB = 14
) (
  input  logic            clk_i,
  input  logic            ce_i,
  input  logic [2*FB:0]   rad_i,
  output logic [FB:0]     root_o
);
  import rmea_pkg::*;

  localparam int RMW = 2 * FB + 1;
  localparam int SQN = FB + 1;

  logic [RMW-1:0] n_q   [SQN];
  logic [RMW-1:0] res_q [SQN];

  for (genvar k = 0; k < SQN; k++) begin : g_step
    localparam logic [RMW-1:0] Bit = RMW'(1) << (2 * (FB - k));
    logic [RMW-1:0] n_in, res_in, n_d, res_d, trial;
    if (k == 0) begin : g_first
      assign n_in   = rad_i;
      assign res_in = '0;
    end else begin : g_next
      assign n_in   = n_q[k-1];
      assign res_in = res_q[k-1];
    end
    always_comb begin
      trial = res_in + Bit;
      if (n_in >= trial) begin
        n_d   = n_in - trial;
        res_d = (res_in >> 1) + Bit;
      end else begin
        n_d   = n_in;
        res_d = res_in >> 1;
      end
    end
    always_ff @(posedge clk_i) begin
      if (ce_i) begin
        n_q[k]   <= n_d;
        res_q[k] <= res_d;
      end
    end
  end

  assign root_o = res_q[SQN-1][FB:0];

endmodule

@@ design/rmea_cordic.sv @@
module rmea_cordic #(
  parameter int DW     = 20,
  parameter int ZW     = 18,
  parameter int STAGES = 16,
  parameter int FB     = 14
) (
  input  logic                 clk_i,
  input  logic                 ce_i,
  input  logic signed [DW-1:0] y_i,
  input  logic signed [DW-1:0] x_i,
  output logic signed [ZW-1:0] z_o
);
  import rmea_pkg::*;

  localparam logic signed [ZW-1:0] Pi = ZW'(pi_fb(FB));

  logic signed [DW-1:0] x_q [STAGES+1];
  logic signed [DW-1:0] y_q [STAGES+1];
  logic signed [ZW-1:0] z_q [STAGES+1];
  logic                 zf_q [STAGES+1];

  logic signed [DW-1:0] x0_d, y0_d;
  logic signed [ZW-1:0] z0_d;

  always_comb begin
    if (x_i < 0) begin
      x0_d = -x_i;
      y0_d = -y_i;
      z0_d = (y_i >= 0) ? Pi : -Pi;
    end else begin
      x0_d = x_i;
      y0_d = y_i;
      z0_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      x_q[0]  <= x0_d;
      y_q[0]  <= y0_d;
      z_q[0]  <= z0_d;
      zf_q[0] <= (x_i == 0) && (y_i == 0);
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_rot
    localparam logic signed [ZW-1:0] Atan = ZW'(atan_fb(i, FB));
    logic signed [DW-1:0] dx, dy;
    assign dx = x_q[i] >>> i;
    assign dy = y_q[i] >>> i;
    always_ff @(posedge clk_i) begin
      if (ce_i) begin
        zf_q[i+1] <= zf_q[i];
        if (y_q[i] >= 0) begin
          x_q[i+1] <= x_q[i] + dy;
          y_q[i+1] <= y_q[i] - dx;
          z_q[i+1] <= z_q[i] + Atan;
        end else begin
          x_q[i+1] <= x_q[i] - dy;
          y_q[i+1] <= y_q[i] + dx;
          z_q[i+1] <= z_q[i] - Atan;
        end
      end
    end
  end

  assign z_o = zf_q[STAGES] ? '0 : z_q[STAGES];

endmodule

@@ sim/rotation_matrix_to_euler_angles_core_tb.sv @@
`timescale 1ns / 1ps

module rotation_matrix_to_euler_angles_core_tb;

  import rmea_pkg::*;

  localparam int FracBits   = FractionBitsDef;
  localparam int Stages     = CordicStagesDef;
  localparam int Latency    = FracBits + Stages + 5;
  localparam int CycleLimit = 400000;
  localparam int NumRandom  = 1850;

  typedef struct packed {
    logic [15:0] r02;
    logic [15:0] r01;
    logic [15:0] r00;
    logic [15:0] r10;
    logic [15:0] r22;
    logic [15:0] r21;
    logic [15:0] r20;
  } matrix_t;

  typedef struct packed {
    logic [4:0]  fill;
    logic [15:0] roll_locked;
    logic [14:0] tilt_locked;
    logic [15:0] heading_b;
    logic [15:0] heading_a;
    logic [15:0] roll_b;
    logic [15:0] roll_a;
    logic [16:0] tilt_b;
    logic [16:0] tilt_a;
    logic [1:0]  pose_case;
  } angles_t;

  logic clk_i;
  logic rst_ni;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [111:0] s_axis_tdata;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [135:0] m_axis_tdata;

  matrix_t pending_q[$];
  angles_t expected_q[$];
  int unsigned errors;
  int unsigned cycles;
  int idle_pct;
  int stall_pct;
  int hold_off;

  rotation_matrix_to_euler_angles_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  function automatic longint shr(input longint v, input int s);
    return v >>> s;
  endfunction

  function automatic longint q14_to_fb(input longint v);
    if (FracBits >= 14) return v * (64'sd1 <<< (FracBits - 14));
    return shr(v + (64'sd1 <<< (13 - FracBits)), 14 - FracBits);
  endfunction

  function automatic longint q30_to_fb(input longint v);
    if (FracBits == 30) return v;
    return shr(v + (64'sd1 <<< (29 - FracBits)), 30 - FracBits);
  endfunction

  function automatic longint fb_to_angle(input longint v, input longint lim);
    longint r;
    if (FracBits > 13) r = shr(v + (64'sd1 <<< (FracBits - 14)), FracBits - 13);
    else r = v * (64'sd1 <<< (13 - FracBits));
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r;
  endfunction

  function automatic longint root_floor(input longint n);
    longint res, bitv;
    res = 0;
    bitv = 64'sd1 <<< 62;
    while (bitv > n) bitv = bitv >>> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >>> 1) + bitv;
      end else begin
        res = res >>> 1;
      end
      bitv = bitv >>> 2;
    end
    return res;
  endfunction

  function automatic longint cordic_atan2(input longint y, input longint x);
    longint z, dx, dy, pi_v, tab;
    z = 0;
    pi_v = q30_to_fb(PiQ30);
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? pi_v : -pi_v;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < Stages; i++) begin
      dx = shr(x, i);
      dy = shr(y, i);
      case (i)
        0: tab = 64'h3243F6A8;   1: tab = 64'h1DAC6705;   2: tab = 64'h0FADBAFC;
        3: tab = 64'h07F56EA6;   4: tab = 64'h03FEAB76;   5: tab = 64'h01FFD55B;
        6: tab = 64'h00FFFAAA;   7: tab = 64'h007FFF55;   8: tab = 64'h003FFFEA;
        9: tab = 64'h001FFFFD;   10: tab = 64'h000FFFFF;  11: tab = 64'h0007FFFF;
        12: tab = 64'h0003FFFF;  13: tab = 64'h0001FFFF;  14: tab = 64'h0000FFFF;
        15: tab = 64'h00007FFF;  16: tab = 64'h00003FFF;  17: tab = 64'h00001FFF;
        18: tab = 64'h00000FFF;  19: tab = 64'h000007FF;  20: tab = 64'h000003FF;
        21: tab = 64'h000001FF;  22: tab = 64'h000000FF;  default: tab = 64'h0000007F;
      endcase
      if (y >= 0) begin
        x = x + dy;
        y = y - dx;
        z = z + q30_to_fb(tab);
      end else begin
        x = x - dy;
        y = y + dx;
        z = z - q30_to_fb(tab);
      end
    end
    return z;
  endfunction

  function automatic angles_t solve_angles(input matrix_t m);
    angles_t a;
    longint raw20, r20, r21, r22, r10, r00, r01, r02, one, r, c, ta;
    a = '0;
    raw20 = longint'($signed(m.r20));
    r20 = q14_to_fb(raw20);
    r21 = q14_to_fb(longint'($signed(m.r21)));
    r22 = q14_to_fb(longint'($signed(m.r22)));
    r10 = q14_to_fb(longint'($signed(m.r10)));
    r00 = q14_to_fb(longint'($signed(m.r00)));
    r01 = q14_to_fb(longint'($signed(m.r01)));
    r02 = q14_to_fb(longint'($signed(m.r02)));
    if (raw20 == -16384) begin
      a.pose_case = CASE_NEG;
      a.tilt_locked = 15'(HalfPiQ13);
      a.roll_locked = 16'(fb_to_angle(cordic_atan2(r01, r02), PiQ13));
    end else if (raw20 == 16384) begin
      a.pose_case = CASE_POS;
      a.tilt_locked = 15'(-HalfPiQ13);
      a.roll_locked = 16'(fb_to_angle(cordic_atan2(-r01, -r02), PiQ13));
    end else begin
      a.pose_case = CASE_NORMAL;
      one = 64'sd1 <<< FracBits;
      r = r20;
      if (r > one) r = one;
      if (r < -one) r = -one;
      c = root_floor(one * one - r * r);
      ta = fb_to_angle(cordic_atan2(-r, c), HalfPiQ13);
      a.tilt_a = 17'(ta);
      a.tilt_b = 17'(PiQ13 - ta);
      a.roll_a = 16'(fb_to_angle(cordic_atan2(r21, r22), PiQ13));
      a.roll_b = 16'(fb_to_angle(cordic_atan2(-r21, -r22), PiQ13));
      a.heading_a = 16'(fb_to_angle(cordic_atan2(r10, r00), PiQ13));
      a.heading_b = 16'(fb_to_angle(cordic_atan2(-r10, -r00), PiQ13));
    end
    return a;
  endfunction

  function automatic logic [15:0] rand_entry();
    case ($urandom_range(0, 9))
      0: return 16'($urandom_range(0, 4) * 8192 - 16384);
      1: return 16'($urandom);
      2: return 16'($urandom_range(0, 64) - 32);
      default: return 16'($urandom_range(0, 32768) - 16384);
    endcase
  endfunction

  function automatic matrix_t rand_matrix();
    matrix_t m;
    m.r20 = rand_entry();
    m.r21 = rand_entry();
    m.r22 = rand_entry();
    m.r10 = rand_entry();
    m.r00 = rand_entry();
    m.r01 = rand_entry();
    m.r02 = rand_entry();
    case ($urandom_range(0, 9))
      0: m.r20 = 16'sd16384;
      1: m.r20 = -16'sd16384;
      2: m.r20 = 16'($urandom_range(16383, 16385));
      3: m.r20 = 16'(-$urandom_range(16383, 16385));
      default: ;
    endcase
    return m;
  endfunction

  function automatic matrix_t mk(input int r20, input int r21, input int r22, input int r10,
                                 input int r00, input int r01, input int r02);
    matrix_t m;
    m.r20 = 16'(r20);
    m.r21 = 16'(r21);
    m.r22 = 16'(r22);
    m.r10 = 16'(r10);
    m.r00 = 16'(r00);
    m.r01 = 16'(r01);
    m.r02 = 16'(r02);
    return m;
  endfunction

  function automatic void add_item(input matrix_t m);
    pending_q = {pending_q, m};
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
    end else begin
      if (!s_axis_tvalid || s_axis_tready) begin
        if (s_axis_tvalid) void'(pending_q.pop_front());
        if (pending_q.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= pending_q[0];
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready)
      expected_q = {expected_q, solve_angles(matrix_t'(s_axis_tdata))};
  end

  always @(posedge clk_i) begin
    if (hold_off > 0) hold_off <= hold_off - 1;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_off > 0) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    angles_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = angles_t'(m_axis_tdata);
      if (expected_q.size() == 0) begin
        $error("unexpected beat %h", m_axis_tdata);
        errors++;
      end else begin
        want = expected_q.pop_front();
        if (got.pose_case !== want.pose_case) begin
          $error("pose_case exp %0d got %0d", want.pose_case, got.pose_case);
          errors++;
        end
        if (got.tilt_a !== want.tilt_a) begin
          $error("tilt_a exp %0d got %0d", $signed(want.tilt_a), $signed(got.tilt_a));
          errors++;
        end
        if (got.tilt_b !== want.tilt_b) begin
          $error("tilt_b exp %0d got %0d", $signed(want.tilt_b), $signed(got.tilt_b));
          errors++;
        end
        if (got.roll_a !== want.roll_a) begin
          $error("roll_a exp %0d got %0d", $signed(want.roll_a), $signed(got.roll_a));
          errors++;
        end
        if (got.roll_b !== want.roll_b) begin
          $error("roll_b exp %0d got %0d", $signed(want.roll_b), $signed(got.roll_b));
          errors++;
        end
        if (got.heading_a !== want.heading_a) begin
          $error("heading_a exp %0d got %0d", $signed(want.heading_a),
                 $signed(got.heading_a));
          errors++;
        end
        if (got.heading_b !== want.heading_b) begin
          $error("heading_b exp %0d got %0d", $signed(want.heading_b),
                 $signed(got.heading_b));
          errors++;
        end
        if (got.tilt_locked !== want.tilt_locked) begin
          $error("tilt_locked exp %0d got %0d", $signed(want.tilt_locked),
                 $signed(got.tilt_locked));
          errors++;
        end
        if (got.roll_locked !== want.roll_locked) begin
          $error("roll_locked exp %0d got %0d", $signed(want.roll_locked),
                 $signed(got.roll_locked));
          errors++;
        end
        if (got.fill !== want.fill) begin
          $error("fill exp %0d got %0d", want.fill, got.fill);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    errors = 0;
    cycles = 0;
    idle_pct = 0;
    stall_pct = 0;
    hold_off = 0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    add_item(mk(0, 0, 16384, 0, 16384, 0, 16384));
    add_item(mk(-16384, 5000, -7000, 100, 200, 16384, 0));
    add_item(mk(16384, 5000, -7000, 100, 200, 16384, -16384));
    add_item(mk(-16384, 0, 0, 0, 0, 0, 0));
    add_item(mk(16384, 0, 0, 0, 0, 0, 0));
    add_item(mk(0, 0, 0, 0, 0, 0, 0));
    add_item(mk(100, 0, -16384, 0, -16384, 0, 0));
    add_item(mk(100, 0, 16384, 0, 16384, 0, 0));
    add_item(mk(32767, 32767, 32767, 32767, 32767, 32767, 32767));
    add_item(mk(-32768, -32768, -32768, -32768, -32768, -32768, -32768));
    add_item(mk(16385, -1, 1, 1, -1, 1, -1));
    add_item(mk(-16385, 16384, -16384, -16384, 16384, 1, 1));
    add_item(mk(16383, -16384, 0, 16384, 0, 0, 0));
    add_item(mk(-16383, 1, -1, -1, 1, -1, 1));
    add_item(mk(8192, 11585, 11585, -11585, 11585, 0, 0));
    add_item(mk(-8192, -16384, -16384, 16384, -16384, 0, 0));

    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 83; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 83; end
        3: begin idle_pct = 6;  stall_pct = 6;  end
        default: begin idle_pct = 0; stall_pct = 0; hold_off = 300; end
      endcase
      for (int n = 0; n < NumRandom / 5; n++) add_item(rand_matrix());
      wait (pending_q.size() == 0);
    end
    stall_pct = 0;
    wait (expected_q.size() == 0);
    repeat (Latency + 10) @(posedge clk_i);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
